### sv/vaui_pkg.sv
// Shared types and constants for the video access unit indexer.
package vaui_pkg;

   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CODE_PICTURE = 8'h00;
   localparam logic [7:0] CODE_SEQ_END = 8'hB7;

   typedef enum logic [2:0] {
      PH_CHECK,
      PH_SKIP,
      PH_SCAN,
      PH_PIC_HIGH,
      PH_PIC_LOW,
      PH_IGNORE
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE,
      EV_ERROR,
      EV_PIC_START,
      EV_SEQ_END,
      EV_PIC_INFO
   } ev_code_type;

   // Event passed from the byte parser to the record builder
   typedef struct packed {
      ev_code_type code;
      logic        last;   // end of stream: back end resets after this event
      logic [9:0]  tref;
      logic [2:0]  kind;
   } event_type;

   function automatic logic [7:0] opening_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = 8'h00;
         2'd1:    b = 8'h00;
         2'd2:    b = 8'h01;
         default: b = 8'hB3;
      endcase
      return b;
   endfunction

endpackage

### sv/vaui_front.sv
// Byte parser: header check, start code search, picture header capture.
module vaui_front
   import vaui_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   input  logic [7:0]             byte_data,
   input  logic                   byte_last,
   output logic                   ev_push,
   output event_type              ev,
   output logic [COUNT_WIDTH-1:0] ev_pos
);

   phase_type              phase_ff, phase_in;
   logic [1:0]             zero_run_ff, zero_run_in;
   logic                   prefix_ff, prefix_in;
   logic [3:0]             skip_ff, skip_in;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]             ref_high_ff, ref_high_in;
   ev_code_type            code;

   always_comb begin
      phase_in    = phase_ff;
      zero_run_in = zero_run_ff;
      prefix_in   = prefix_ff;
      skip_in     = skip_ff;
      ref_high_in = ref_high_ff;
      pos_in      = pos_ff;
      code        = EV_NONE;
      ev_pos      = pos_ff;

      if (byte_valid) begin
         unique case (phase_ff)
            PH_CHECK: begin
               if (byte_data != opening_byte(pos_ff[1:0])) begin
                  code     = EV_ERROR;
                  phase_in = PH_IGNORE;
               end else if (pos_ff >= COUNT_WIDTH'(3)) begin
                  phase_in = PH_SKIP;
                  skip_in  = 4'(HEADER_BYTES);
               end
            end
            PH_SKIP: begin
               if (skip_ff <= 4'd1) begin
                  skip_in  = 4'd0;
                  phase_in = PH_SCAN;
               end else begin
                  skip_in = skip_ff - 4'd1;
               end
            end
            PH_SCAN: begin
               if (prefix_ff) begin
                  prefix_in   = 1'b0;
                  zero_run_in = 2'd0;
                  if (byte_data == CODE_PICTURE) begin
                     code     = EV_PIC_START;
                     ev_pos   = pos_ff - COUNT_WIDTH'(3);
                     phase_in = PH_PIC_HIGH;
                  end else if (byte_data == CODE_SEQ_END) begin
                     code   = EV_SEQ_END;
                     ev_pos = pos_ff + COUNT_WIDTH'(1);
                  end
               end else if (byte_data == 8'h00) begin
                  if (zero_run_ff != 2'd2) zero_run_in = zero_run_ff + 2'd1;
               end else if (byte_data == 8'h01 && zero_run_ff == 2'd2) begin
                  prefix_in   = 1'b1;
                  zero_run_in = 2'd0;
               end else begin
                  zero_run_in = 2'd0;
               end
            end
            PH_PIC_HIGH: begin
               ref_high_in = byte_data;
               phase_in    = PH_PIC_LOW;
            end
            PH_PIC_LOW: begin
               code        = EV_PIC_INFO;
               zero_run_in = 2'd0;
               prefix_in   = 1'b0;
               phase_in    = PH_SCAN;
            end
            PH_IGNORE: ;
            default: ;
         endcase

         pos_in = pos_ff + COUNT_WIDTH'(1);
         if (byte_last) begin
            phase_in    = PH_CHECK;
            zero_run_in = 2'd0;
            prefix_in   = 1'b0;
            skip_in     = 4'd0;
            pos_in      = '0;
            ref_high_in = 8'd0;
         end
      end

      ev.code = code;
      ev.last = byte_last;
      ev.tref = {ref_high_ff, byte_data[7:6]};
      ev.kind = byte_data[5:3];
      ev_push = byte_valid && (code != EV_NONE || byte_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CHECK;
         zero_run_ff <= 2'd0;
         prefix_ff   <= 1'b0;
         skip_ff     <= 4'd0;
         pos_ff      <= '0;
         ref_high_ff <= 8'd0;
      end else begin
         phase_ff    <= phase_in;
         zero_run_ff <= zero_run_in;
         prefix_ff   <= prefix_in;
         skip_ff     <= skip_in;
         pos_ff      <= pos_in;
         ref_high_ff <= ref_high_in;
      end
   end

endmodule

### sv/vaui_queue.sv
// Short event queue between the byte parser and the record builder.
module vaui_queue
   import vaui_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output logic [DATA_WIDTH-1:0] head_data
);

   logic [DATA_WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_pop;

   always_comb begin
      full      = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head_data = mem_ff[rd_ff];
      do_pop    = pop && not_empty;
      wr_in     = push ? wr_ff + 1'b1 : wr_ff;
      rd_in     = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in  = count_ff;
      if (push && !do_pop) count_in = count_ff + 1'b1;
      else if (!push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

### sv/vaui_back.sv
// Record builder: unit lengths, decode and presentation order, output register.
module vaui_back
   import vaui_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ev_valid,
   input  event_type              ev,
   input  logic [COUNT_WIDTH-1:0] ev_pos,
   output logic                   ev_pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   out_kind,
   output logic [31:0]            out_length,
   output logic [2:0]             out_picture,
   output logic [31:0]            out_decode,
   output logic [31:0]            out_present
);

   logic [COUNT_WIDTH-1:0] unit_start_ff, unit_start_in;
   logic [COUNT_WIDTH-1:0] decode_ff, decode_in;
   logic [COUNT_WIDTH-1:0] base_ff, base_in;
   logic [2:0]             held_kind_ff, held_kind_in;
   logic [COUNT_WIDTH-1:0] held_decode_ff, held_decode_in;
   logic [COUNT_WIDTH-1:0] held_present_ff, held_present_in;
   logic                   first_ff, first_in;

   logic                   valid_ff, valid_in;
   logic                   kind_ff, kind_in;
   logic [31:0]            length_ff, length_in;
   logic [2:0]             picture_ff, picture_in;
   logic [31:0]            decode_out_ff, decode_out_in;
   logic [31:0]            present_ff, present_in;

   logic [COUNT_WIDTH-1:0] unit_len;
   logic [COUNT_WIDTH-1:0] base_sel;
   logic                   emit;
   logic                   emit_rec;

   always_comb begin
      ev_pop   = ev_valid && (!valid_ff || out_ready);
      unit_len = ev_pos - unit_start_ff;
      base_sel = (ev.kind == 3'd1) ? decode_ff : base_ff;

      unit_start_in   = unit_start_ff;
      decode_in       = decode_ff;
      base_in         = base_ff;
      held_kind_in    = held_kind_ff;
      held_decode_in  = held_decode_ff;
      held_present_in = held_present_ff;
      first_in        = first_ff;
      emit            = 1'b0;
      emit_rec        = 1'b0;

      if (ev_pop) begin
         unique case (ev.code)
            EV_ERROR:     emit = 1'b1;
            EV_PIC_START: begin
               if (first_ff) first_in = 1'b0;
               else emit_rec = 1'b1;
            end
            EV_SEQ_END:   emit_rec = 1'b1;
            EV_PIC_INFO: begin
               base_in         = base_sel;
               held_kind_in    = ev.kind;
               held_decode_in  = decode_ff;
               held_present_in = COUNT_WIDTH'(ev.tref) + base_sel;
               decode_in       = decode_ff + COUNT_WIDTH'(1);
            end
            EV_NONE: ;
            default: ;
         endcase
         if (emit_rec) begin
            emit          = 1'b1;
            unit_start_in = ev_pos;
         end
         if (ev.last) begin
            unit_start_in   = '0;
            decode_in       = '0;
            base_in         = '0;
            held_kind_in    = 3'd0;
            held_decode_in  = '0;
            held_present_in = '0;
            first_in        = 1'b1;
         end
      end

      kind_in       = kind_ff;
      length_in     = length_ff;
      picture_in    = picture_ff;
      decode_out_in = decode_out_ff;
      present_in    = present_ff;
      if (emit) begin
         kind_in       = !emit_rec;
         length_in     = emit_rec ? 32'(unit_len) : 32'd0;
         picture_in    = emit_rec ? held_kind_ff : 3'd0;
         decode_out_in = emit_rec ? 32'(held_decode_ff) : 32'd0;
         present_in    = emit_rec ? 32'(held_present_ff) : 32'd0;
      end
      valid_in = emit || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         unit_start_ff   <= '0;
         decode_ff       <= '0;
         base_ff         <= '0;
         held_kind_ff    <= 3'd0;
         held_decode_ff  <= '0;
         held_present_ff <= '0;
         first_ff        <= 1'b1;
      end else begin
         valid_ff        <= valid_in;
         unit_start_ff   <= unit_start_in;
         decode_ff       <= decode_in;
         base_ff         <= base_in;
         held_kind_ff    <= held_kind_in;
         held_decode_ff  <= held_decode_in;
         held_present_ff <= held_present_in;
         first_ff        <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      length_ff     <= length_in;
      picture_ff    <= picture_in;
      decode_out_ff <= decode_out_in;
      present_ff    <= present_in;
   end

   assign out_valid   = valid_ff;
   assign out_kind    = kind_ff;
   assign out_length  = length_ff;
   assign out_picture = picture_ff;
   assign out_decode  = decode_out_ff;
   assign out_present = present_ff;

endmodule

### sv/video_access_unit_indexer.sv
// Video access unit indexer: MPEG-1/2 start code parser producing access unit records.
// Throughput: one stream byte per cycle, limited by the byte parser state register, while
// the event queue is not full. A record reaches rsp after the byte that closes its unit,
// through the event queue, then the record builder into the output register.
// The four-entry event queue lets the parser run on while the result side stalls.
// Reset (synchronous, active high) and an item with tlast both return all state to start.
module video_access_unit_indexer
   import vaui_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] stream_byte
   input  logic         req_tlast,   // end_of_stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [31:0] unit_length, [34:32] picture_kind,
                                     // [66:35] decode_index, [98:67] present_index
   output logic [0:0]   rsp_tuser    // [0] result_kind
);

   localparam int unsigned EV_BITS = $bits(event_type);
   localparam int unsigned Q_WIDTH = EV_BITS + COUNT_WIDTH;

   logic                   q_full, q_not_empty, push, pop, byte_valid;
   event_type              ev_front, ev_back;
   logic [COUNT_WIDTH-1:0] pos_front;
   logic [Q_WIDTH-1:0]     q_head;
   logic                   out_kind;
   logic [31:0]            out_length, out_decode, out_present;
   logic [2:0]             out_picture;

   assign req_tready = !q_full;
   assign byte_valid = req_tvalid && !q_full;

   vaui_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (req_tdata),
      .byte_last  (req_tlast),
      .ev_push    (push),
      .ev         (ev_front),
      .ev_pos     (pos_front)
   );

   vaui_queue #(.DATA_WIDTH(Q_WIDTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({pos_front, ev_front}),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   assign ev_back = event_type'(q_head[EV_BITS-1:0]);

   vaui_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .ev_valid    (q_not_empty),
      .ev          (ev_back),
      .ev_pos      (q_head[Q_WIDTH-1:EV_BITS]),
      .ev_pop      (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (out_kind),
      .out_length  (out_length),
      .out_picture (out_picture),
      .out_decode  (out_decode),
      .out_present (out_present)
   );

   assign rsp_tdata = {5'd0, out_present, out_decode, out_picture, out_length};
   assign rsp_tuser = out_kind;

endmodule

### tb/tb_video_access_unit_indexer.sv
// Self-checking testbench for the video access unit indexer: directed and random byte streams.
`timescale 1ns / 1ps

module tb_video_access_unit_indexer;
   import vaui_pkg::*;

   localparam logic [7:0]  SEQ_HEADER_CODE = 8'hB3;
   localparam logic [7:0]  PREFIX_ONE      = 8'h01;
   localparam logic        KIND_RECORD     = 1'b0;
   localparam logic        KIND_BAD_START  = 1'b1;
   localparam logic [2:0]  PIC_I           = 3'd1;
   localparam logic [2:0]  PIC_D           = 3'd4;
   localparam int unsigned RANDOM_BYTES    = 300;
   localparam int unsigned NOISE_FRAMES    = 14;
   localparam int unsigned DRAIN_CYCLES    = 20;
   localparam int unsigned CYCLE_LIMIT     = 200000;

   typedef struct packed {
      logic        kind;
      logic [31:0] len;
      logic [2:0]  pic;
      logic [31:0] dec;
      logic [31:0] pres;
   } au_record_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] stream_byte
   logic         req_tlast;   // end_of_stream
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;   // [31:0] unit_length, [34:32] picture_kind,
                              // [66:35] decode_index, [98:67] present_index
   logic [0:0]   rsp_tuser;   // [0] result_kind

   // indexer state as the testbench sees it
   phase_type   parse_phase;
   logic [1:0]  zero_count;
   logic        prefix_hit;
   logic [3:0]  skip_count;
   logic [31:0] stream_pos;
   logic [31:0] unit_begin;
   logic [31:0] decode_count;
   logic [31:0] group_base;
   logic [2:0]  held_kind;
   logic [31:0] held_decode;
   logic [31:0] held_present;
   logic        awaiting_first;
   logic [7:0]  ref_high;

   au_record_type awaited_records[$];
   logic [7:0]    frame[$];

   bit          src_idle = 1'b1;
   bit          snk_idle = 1'b1;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned frames_sent = 0;
   int unsigned clean_bytes = 0;
   int unsigned records_seen = 0;
   int unsigned bad_starts_seen = 0;

   video_access_unit_indexer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic clear_indexer_state();
      parse_phase    = PH_CHECK;
      zero_count     = '0;
      prefix_hit     = 1'b0;
      skip_count     = '0;
      stream_pos     = '0;
      unit_begin     = '0;
      decode_count   = '0;
      group_base     = '0;
      held_kind      = '0;
      held_decode    = '0;
      held_present   = '0;
      awaiting_first = 1'b1;
      ref_high       = '0;
   endtask

   task automatic close_unit(input logic [31:0] unit_end);
      awaited_records.push_back('{KIND_RECORD, unit_end - unit_begin, held_kind,
                                  held_decode, held_present});
      unit_begin = unit_end;
   endtask

   // advances the indexer by one accepted byte and queues any record it yields
   task automatic index_byte(input logic [7:0] b, input logic last);
      logic [31:0] pos;
      logic [7:0]  opening;
      logic [9:0]  tref;
      logic [2:0]  coding;
      pos = stream_pos;
      case (parse_phase)
         PH_CHECK: begin
            case (pos[1:0])
               2'd2:    opening = PREFIX_ONE;
               2'd3:    opening = SEQ_HEADER_CODE;
               default: opening = 8'h00;
            endcase
            if (b != opening) begin
               awaited_records.push_back('{KIND_BAD_START, 32'd0, 3'd0, 32'd0, 32'd0});
               parse_phase = PH_IGNORE;
            end else if (pos >= 32'd3) begin
               parse_phase = PH_SKIP;
               skip_count  = 4'(HEADER_BYTES);
            end
         end
         PH_SKIP: begin
            if (skip_count != 0) skip_count--;
            if (skip_count == 0) parse_phase = PH_SCAN;
         end
         PH_SCAN: begin
            if (prefix_hit) begin
               prefix_hit = 1'b0;
               zero_count = '0;
               if (b == CODE_PICTURE) begin
                  // the first picture opens the first unit at byte 0
                  if (awaiting_first) awaiting_first = 1'b0;
                  else close_unit(pos - 32'd3);
                  parse_phase = PH_PIC_HIGH;
               end else if (b == CODE_SEQ_END) begin
                  close_unit(pos + 32'd1);
               end
            end else if (b == 8'h00) begin
               if (zero_count < 2'd2) zero_count++;
            end else if (b == PREFIX_ONE && zero_count == 2'd2) begin
               prefix_hit = 1'b1;
               zero_count = '0;
            end else begin
               zero_count = '0;
            end
         end
         PH_PIC_HIGH: begin
            ref_high    = b;
            parse_phase = PH_PIC_LOW;
         end
         PH_PIC_LOW: begin
            tref   = {ref_high, b[7:6]};
            coding = b[5:3];
            if (coding == PIC_I) group_base = decode_count;
            held_kind    = coding;
            held_decode  = decode_count;
            held_present = 32'(tref) + group_base;
            decode_count++;
            zero_count   = '0;
            prefix_hit   = 1'b0;
            parse_phase  = PH_SCAN;
         end
         default: ;
      endcase
      stream_pos++;
      if (last) clear_indexer_state();
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = src_idle ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      index_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
      frames_sent++;
   endtask

   task automatic add_start_code(input logic [7:0] code, input int unsigned extra_zeros);
      repeat (2 + extra_zeros) frame.push_back(8'h00);
      frame.push_back(PREFIX_ONE);
      frame.push_back(code);
   endtask

   task automatic check_result();
      au_record_type seen;
      au_record_type want;
      seen = '{rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[34:32], rsp_tdata[66:35],
               rsp_tdata[98:67]};
      if (seen.kind == KIND_BAD_START) bad_starts_seen++;
      else records_seen++;
      if (awaited_records.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("ERROR: unexpected item kind=%0d len=%0d pic=%0d dec=%0d pres=%0d",
                     seen.kind, seen.len, seen.pic, seen.dec, seen.pres);
      end else begin
         want = awaited_records.pop_front();
         if (seen.kind !== want.kind || seen.len !== want.len || seen.pic !== want.pic ||
             seen.dec !== want.dec || seen.pres !== want.pres) begin
            error_count++;
            if (error_count <= 10) begin
               $display("ERROR: exp kind=%0d len=%0d pic=%0d dec=%0d pres=%0d",
                        want.kind, want.len, want.pic, want.dec, want.pres);
               $display("       got kind=%0d len=%0d pic=%0d dec=%0d pres=%0d",
                        seen.kind, seen.len, seen.pic, seen.dec, seen.pres);
            end
         end
      end
   endtask

   // result side: check each item, then drop ready for a random stall while snk_idle is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
            stall_left = snk_idle ? $urandom_range(0, 4) : 0;
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic test_bad_start();
      frame.delete();
      frame.push_back(SEQ_HEADER_CODE);
      send_frame();
      // error on the third byte, the rest is dropped until end of stream
      frame.delete();
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      frame.push_back(8'h02);
      frame.push_back(8'hFF);
      send_frame();
   endtask

   task automatic test_special_cases();
      frame.delete();
      add_start_code(SEQ_HEADER_CODE, 0);
      // start codes inside the skipped header must have no effect
      add_start_code(CODE_PICTURE, 0);
      add_start_code(CODE_SEQ_END, 0);
      // sequence end before any picture
      add_start_code(CODE_SEQ_END, 0);
      // first picture, coding type 0; header zeros must not feed a prefix
      add_start_code(CODE_PICTURE, 0);
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      frame.push_back(PREFIX_ONE);
      // long zero run, then max temporal reference with coding type 7
      add_start_code(CODE_PICTURE, 2);
      frame.push_back(8'hFF);
      frame.push_back(8'hF8);
      add_start_code(CODE_PICTURE, 0);
      frame.push_back(8'h00);
      frame.push_back({2'b00, PIC_I, 3'b000});
      add_start_code(CODE_SEQ_END, 0);
      send_frame();
   endtask

   task automatic test_well_formed_streams();
      int unsigned units;
      int unsigned cut;
      logic [2:0]  coding;
      while (clean_bytes < RANDOM_BYTES) begin
         frame.delete();
         src_idle = ($urandom_range(0, 3) != 0);
         snk_idle = ($urandom_range(0, 3) != 0);
         add_start_code(SEQ_HEADER_CODE, 0);
         repeat (HEADER_BYTES) frame.push_back(8'($urandom));
         units = $urandom_range(1, 8);
         repeat (units) begin
            if ($urandom_range(0, 7) == 0) begin
               add_start_code(CODE_SEQ_END, $urandom_range(0, 2));
            end else begin
               add_start_code(CODE_PICTURE,
                              ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
               if ($urandom_range(0, 7) == 0) coding = 3'($urandom);
               else coding = 3'($urandom_range(PIC_I, PIC_D));
               frame.push_back(8'($urandom));
               frame.push_back({2'($urandom), coding, 3'($urandom)});
            end
            // payload leans toward 00 and 01 so stray prefixes show up
            repeat ($urandom_range(0, 10)) begin
               case ($urandom_range(0, 5))
                  0:       frame.push_back(8'h00);
                  1:       frame.push_back(PREFIX_ONE);
                  default: frame.push_back(8'($urandom));
               endcase
            end
         end
         if ($urandom_range(0, 1) == 1) add_start_code(CODE_SEQ_END, 0);
         // sometimes end the stream anywhere, even inside a header or start code
         if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut) void'(frame.pop_back());
         end
         clean_bytes += frame.size();
         send_frame();
      end
   endtask

   task automatic test_noise_streams();
      int unsigned idx;
      repeat (NOISE_FRAMES) begin
         frame.delete();
         src_idle = ($urandom_range(0, 3) != 0);
         snk_idle = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
         end else begin
            add_start_code(SEQ_HEADER_CODE, 0);
            idx = $urandom_range(0, 3);
            frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
            repeat ($urandom_range(0, 4)) frame.push_back(8'($urandom));
         end
         send_frame();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      clear_indexer_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_bad_start();
      test_special_cases();
      test_well_formed_streams();
      test_noise_streams();

      req_tvalid <= 1'b0;
      while (awaited_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d streams (%0d in well-formed random streams).",
               bytes_sent, frames_sent, clean_bytes);
      $display("Checked %0d access unit records and %0d bad-start reports, %0d errors.",
               records_seen, bad_starts_seen, error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
sv/vaui_pkg.sv
sv/vaui_front.sv
sv/vaui_queue.sv
sv/vaui_back.sv
sv/video_access_unit_indexer.sv
tb/tb_video_access_unit_indexer.sv
